FILE: design/np2b_pkg.sv
// ----------------------------------------------------------------------------
// np2b_pkg: shared types and constants of the nucleotide two-bit packer
//
// Holds the channel payload types, the bundle that travels from the front
// stage to the result sequencer, the character codes and register indexes.
// ----------------------------------------------------------------------------
package np2b_pkg;

   // Word and field geometry.
   localparam int CODES_PER_WORD = 32;
   localparam int WORD_W         = 64;
   localparam int SLOT_W         = 5;
   localparam int INDEX_W        = 23;
   localparam int SIZE_W         = 28;
   localparam int COUNT_W        = 29;
   localparam int CHAR_W         = 8;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 28;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERLEAVED_MODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GENOME_SIZE      = 1'd1;

   // Register reset values.
   localparam logic              INTERLEAVED_RESET = 1'b1;
   localparam logic [SIZE_W-1:0] GENOME_SIZE_RESET = 28'd1024;

   // Characters that carry a nucleotide.
   localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
   localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

   // Two-bit nucleotide codes.
   localparam logic [1:0] CODE_A = 2'd0;
   localparam logic [1:0] CODE_C = 2'd1;
   localparam logic [1:0] CODE_G = 2'd2;
   localparam logic [1:0] CODE_T = 2'd3;

   // Result kinds and status codes.
   localparam logic KIND_DATA       = 1'b0;
   localparam logic KIND_STATUS     = 1'b1;
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   // Slot that completes a word.
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CODES_PER_WORD - 1);

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              end_of_input;
   } request_type;

   typedef struct packed {
      logic               kind;
      logic               strand;
      logic [INDEX_W-1:0] word_index;
      logic [WORD_W-1:0]  packed_word;
      logic               status;
      logic               last_of_item;
   } response_type;

   // All results caused by one input character, in delivery order:
   // word A, then word B (always strand 1), then the status result.
   typedef struct packed {
      logic               a_valid;
      logic               a_strand;
      logic [INDEX_W-1:0] word_index;
      logic [WORD_W-1:0]  a_word;
      logic               b_valid;
      logic [WORD_W-1:0]  b_word;
      logic               s_valid;
      logic               status;
   } bundle_type;

endpackage

FILE: design/np2b_stream_if.sv
// ----------------------------------------------------------------------------
// np2b_stream_if: valid/ready stream channel
//
// Carries one payload per transfer; a transfer happens at a rising clock edge
// at which valid and ready are both high.
// ----------------------------------------------------------------------------
interface np2b_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

FILE: design/np2b_front.sv
// ----------------------------------------------------------------------------
// np2b_front: character classification and word packing
//
// Maps each character to a nucleotide code, updates the strand accumulators,
// counters and configuration registers, and hands every result that a
// character causes to the queue as one bundle.
// ----------------------------------------------------------------------------
module np2b_front (
   input  logic                            clock,
   input  logic                            reset,
   np2b_stream_if.sink                     req_if,
   input  logic                            csr_write_enable,
   input  logic [np2b_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [np2b_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            queue_full,
   output logic                            push,
   output np2b_pkg::bundle_type            push_bundle
);

   // Configuration registers.
   logic                           interleaved_ff;
   logic [np2b_pkg::SIZE_W-1:0]    genome_size_ff;

   // Stream state.
   logic [np2b_pkg::WORD_W-1:0]    acc0_ff, acc0_in;
   logic [np2b_pkg::WORD_W-1:0]    acc1_ff, acc1_in;
   logic [np2b_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [np2b_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                           phase_ff, phase_in;
   logic [np2b_pkg::INDEX_W-1:0]   index_ff, index_in;

   logic                           accept;
   logic                           is_base;
   logic [1:0]                     code;
   logic [np2b_pkg::COUNT_W-1:0]   total;
   logic [np2b_pkg::COUNT_W-1:0]   count_next;
   logic [np2b_pkg::WORD_W-1:0]    code_shifted;
   logic [np2b_pkg::WORD_W-1:0]    acc_sel;
   logic [np2b_pkg::WORD_W-1:0]    acc_new;
   logic [np2b_pkg::SLOT_W-1:0]    slot_next;
   logic [np2b_pkg::INDEX_W-1:0]   index_next;
   logic                           slot_full;
   logic                           first_end;
   logic                           final_end;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && req_if.ready;

   // Character to code mapping; anything else is dropped.
   always_comb begin
      is_base = 1'b1;
      case (req_if.payload.char_code)
         np2b_pkg::CHAR_A: code = np2b_pkg::CODE_A;
         np2b_pkg::CHAR_C: code = np2b_pkg::CODE_C;
         np2b_pkg::CHAR_G: code = np2b_pkg::CODE_G;
         np2b_pkg::CHAR_T: code = np2b_pkg::CODE_T;
         default: begin
            code    = np2b_pkg::CODE_A;
            is_base = 1'b0;
         end
      endcase
   end

   // Shared terms of the packing paths.
   assign total        = {genome_size_ff, 1'b0};
   assign count_next   = np2b_pkg::COUNT_W'(count_ff + 1'b1);
   assign code_shifted = {{(np2b_pkg::WORD_W-2){1'b0}}, code} << {slot_ff, 1'b0};
   assign acc_sel      = phase_ff ? acc1_ff : acc0_ff;
   assign acc_new      = acc_sel | code_shifted;
   assign slot_next    = np2b_pkg::SLOT_W'(slot_ff + 1'b1);
   assign index_next   = np2b_pkg::INDEX_W'(index_ff + 1'b1);
   assign slot_full    = (slot_ff == np2b_pkg::LAST_SLOT);
   assign first_end    = !phase_ff && (count_next == {1'b0, genome_size_ff});
   assign final_end    = !first_end && (count_next == total);

   // Next stream state and the bundle of results for this character.
   always_comb begin
      acc0_in     = acc0_ff;
      acc1_in     = acc1_ff;
      slot_in     = slot_ff;
      count_in    = count_ff;
      phase_in    = phase_ff;
      index_in    = index_ff;
      push        = 1'b0;
      push_bundle = '0;
      push_bundle.word_index = index_ff;

      if (accept) begin
         if (req_if.payload.end_of_input) begin
            // Flush partial words, report the count check, start a new stream.
            if (interleaved_ff) begin
               push_bundle.a_valid  = (slot_ff != '0) || phase_ff;
               push_bundle.a_strand = 1'b0;
               push_bundle.a_word   = acc0_ff;
               push_bundle.b_valid  = (slot_ff != '0);
               push_bundle.b_word   = acc1_ff;
            end else begin
               push_bundle.a_valid  = (slot_ff != '0);
               push_bundle.a_strand = phase_ff;
               push_bundle.a_word   = acc_sel;
            end
            push_bundle.s_valid = 1'b1;
            push_bundle.status  = (count_ff != total) ? np2b_pkg::STATUS_MISMATCH
                                                      : np2b_pkg::STATUS_OK;
            push     = 1'b1;
            acc0_in  = '0;
            acc1_in  = '0;
            slot_in  = '0;
            count_in = '0;
            phase_in = 1'b0;
            index_in = '0;
         end else if (is_base) begin
            if (count_ff < total) begin
               count_in = count_next;
               if (interleaved_ff) begin
                  // Codes alternate strands; a pair fills one slot of each word.
                  if (!phase_ff) begin
                     acc0_in  = acc0_ff | code_shifted;
                     phase_in = 1'b1;
                  end else begin
                     phase_in = 1'b0;
                     if (slot_full) begin
                        push_bundle.a_valid  = 1'b1;
                        push_bundle.a_strand = 1'b0;
                        push_bundle.a_word   = acc0_ff;
                        push_bundle.b_valid  = 1'b1;
                        push_bundle.b_word   = acc1_ff | code_shifted;
                        push     = 1'b1;
                        acc0_in  = '0;
                        acc1_in  = '0;
                        slot_in  = '0;
                        index_in = index_next;
                     end else begin
                        acc1_in = acc1_ff | code_shifted;
                        slot_in = slot_next;
                     end
                  end
               end else begin
                  // Sequential strands; a full word or a strand end emits a word.
                  if (slot_full || first_end || final_end) begin
                     push_bundle.a_valid  = 1'b1;
                     push_bundle.a_strand = phase_ff;
                     push_bundle.a_word   = acc_new;
                     push     = 1'b1;
                     slot_in  = '0;
                     index_in = first_end ? '0 : index_next;
                     if (phase_ff) begin
                        acc1_in = '0;
                     end else begin
                        acc0_in = '0;
                     end
                  end else begin
                     slot_in = slot_next;
                     if (phase_ff) begin
                        acc1_in = acc_new;
                     end else begin
                        acc0_in = acc_new;
                     end
                  end
                  if (first_end) begin
                     phase_in = 1'b1;
                  end
               end
            end else if (count_ff == total) begin
               // One excess code marks the mismatch; further ones change nothing.
               count_in = count_next;
            end
         end
      end
   end

   // Configuration registers and stream state.
   always_ff @(posedge clock) begin
      if (reset) begin
         interleaved_ff <= np2b_pkg::INTERLEAVED_RESET;
         genome_size_ff <= np2b_pkg::GENOME_SIZE_RESET;
         acc0_ff        <= '0;
         acc1_ff        <= '0;
         slot_ff        <= '0;
         count_ff       <= '0;
         phase_ff       <= 1'b0;
         index_ff       <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               np2b_pkg::CSR_INTERLEAVED_MODE: interleaved_ff <= csr_write_data[0];
               np2b_pkg::CSR_GENOME_SIZE:      genome_size_ff <= csr_write_data;
               default: ;
            endcase
         end
         acc0_ff  <= acc0_in;
         acc1_ff  <= acc1_in;
         slot_ff  <= slot_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         index_ff <= index_in;
      end
   end

endmodule

FILE: design/np2b_queue.sv
// ----------------------------------------------------------------------------
// np2b_queue: bundle queue between front stage and result sequencer
//
// A small circular buffer that lets the packer keep taking characters while
// results of earlier characters wait on the result channel.
// ----------------------------------------------------------------------------
module np2b_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  np2b_pkg::bundle_type push_bundle,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output np2b_pkg::bundle_type head_bundle
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   np2b_pkg::bundle_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] fill_ff, fill_in;

   assign full        = (fill_ff == COUNT_W'(DEPTH));
   assign head_valid  = (fill_ff != '0);
   assign head_bundle = entries_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         fill_in = COUNT_W'(fill_ff + 1'b1);
      end else if (pop && !push) begin
         fill_in = COUNT_W'(fill_ff - 1'b1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

FILE: design/np2b_back.sv
// ----------------------------------------------------------------------------
// np2b_back: result sequencer
//
// Walks the head bundle of the queue one result at a time into the output
// register and marks the last result of each character.
// ----------------------------------------------------------------------------
module np2b_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  np2b_pkg::bundle_type head_bundle,
   output logic                 pop,
   np2b_stream_if.source        rsp_if
);

   logic                   rsp_valid_ff;
   np2b_pkg::response_type rsp_ff, rsp_in;
   logic                   a_done_ff, a_done_in;
   logic                   b_done_ff, b_done_in;
   logic                   load;
   logic                   sel_a;
   logic                   sel_b;
   logic                   last;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // The output register takes a new result when it is empty or being drained.
   assign load  = head_valid && (!rsp_valid_ff || rsp_if.ready);
   assign sel_a = head_bundle.a_valid && !a_done_ff;
   assign sel_b = !sel_a && head_bundle.b_valid && !b_done_ff;

   // Pick the next pending result of the head bundle.
   always_comb begin
      rsp_in = '0;
      if (sel_a) begin
         rsp_in.kind        = np2b_pkg::KIND_DATA;
         rsp_in.strand      = head_bundle.a_strand;
         rsp_in.word_index  = head_bundle.word_index;
         rsp_in.packed_word = head_bundle.a_word;
         last = !(head_bundle.b_valid || head_bundle.s_valid);
      end else if (sel_b) begin
         rsp_in.kind        = np2b_pkg::KIND_DATA;
         rsp_in.strand      = 1'b1;
         rsp_in.word_index  = head_bundle.word_index;
         rsp_in.packed_word = head_bundle.b_word;
         last = !head_bundle.s_valid;
      end else begin
         rsp_in.kind   = np2b_pkg::KIND_STATUS;
         rsp_in.status = head_bundle.status;
         last = 1'b1;
      end
      rsp_in.last_of_item = last;
   end

   assign pop = load && last;

   // Progress through the head bundle.
   always_comb begin
      a_done_in = a_done_ff;
      b_done_in = b_done_ff;
      if (load) begin
         if (last) begin
            a_done_in = 1'b0;
            b_done_in = 1'b0;
         end else if (sel_a) begin
            a_done_in = 1'b1;
         end else begin
            b_done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         a_done_ff    <= 1'b0;
         b_done_ff    <= 1'b0;
      end else begin
         a_done_ff <= a_done_in;
         b_done_ff <= b_done_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: design/nucleotide_two_bit_packer.sv
// ----------------------------------------------------------------------------
// nucleotide_two_bit_packer: DNA character stream to 2-bit packed words
//
// Packs A/C/G/T characters 32 to a 64-bit word per strand and reports a
// final length check when the end marker arrives.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle for as long as its internal
// queue (QUEUE_DEPTH bundles) has room. A character that completes words, or
// the end marker, causes one to three results, and the result port delivers
// one result per cycle while the receiver is ready, so such a character
// holds the result port until all its results are out, while the queue
// absorbs the characters behind it. The first result of a character passes
// through the queue and then the output register. Write
// interleaved_mode (index 0, reset 1) and genome_size (index 1, reset 1024)
// only while the block is idle. When the end marker is taken the stream state is
// cleared and the block is ready for the next stream.
module nucleotide_two_bit_packer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   np2b_stream_if.sink                      req_if,
   np2b_stream_if.source                    rsp_if,
   input  logic                             csr_write_enable,
   input  logic [np2b_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [np2b_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   logic                 queue_full;
   logic                 push;
   np2b_pkg::bundle_type push_bundle;
   logic                 pop;
   logic                 head_valid;
   np2b_pkg::bundle_type head_bundle;

   // Classification, packing and configuration.
   np2b_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_bundle      (push_bundle)
   );

   // Decoupling queue.
   np2b_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .full        (queue_full),
      .pop         (pop),
      .head_valid  (head_valid),
      .head_bundle (head_bundle)
   );

   // Result sequencing onto the output channel.
   np2b_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_bundle (head_bundle),
      .pop         (pop),
      .rsp_if      (rsp_if)
   );

endmodule

FILE: sim/nucleotide_two_bit_packer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nucleotide_two_bit_packer_test: self-checking bench of the two-bit packer
//
// Drives character streams into the packer through the request channel and
// checks every packed word and status result against a cycle-free model of
// the packing rules. A short table of directed rows comes first, then random
// streams under several idle and stall patterns, with register changes made
// only while the block is idle.
// ----------------------------------------------------------------------------
module nucleotide_two_bit_packer_test;

   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 75;

   localparam int WORD_W  = np2b_pkg::WORD_W;
   localparam int SIZE_W  = np2b_pkg::SIZE_W;
   localparam int COUNT_W = np2b_pkg::COUNT_W;
   localparam int CHAR_W  = np2b_pkg::CHAR_W;
   localparam int DATA_W  = np2b_pkg::CSR_DATA_W;

   localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

   // Whether a directed row is checked against a typed-in status result.
   localparam logic CHECK_PREDICTED = 1'b0;
   localparam logic CHECK_TYPED     = 1'b1;

   typedef enum logic [1:0] {
      ROW_CHAR,
      ROW_END,
      ROW_SET_MODE,
      ROW_SET_SIZE
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [DATA_W-1:0] value;
      logic              typed;
      logic              typed_status;
   } directed_row_type;

   logic                             clock            = 1'b0;
   logic                             reset            = 1'b1;
   logic                             csr_write_enable = 1'b0;
   logic [np2b_pkg::CSR_INDEX_W-1:0] csr_index        = np2b_pkg::CSR_INTERLEAVED_MODE;
   logic [DATA_W-1:0]                csr_write_data   = '0;

   np2b_stream_if #(.payload_type(np2b_pkg::request_type))  req_if ();
   np2b_stream_if #(.payload_type(np2b_pkg::response_type)) rsp_if ();

   nucleotide_two_bit_packer dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Period of 8 ns.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Directed rows: extremes, noise bytes, every register, the special cases.
   directed_row_type directed_table [33] = '{
      // End marker right after reset: no codes against 1024 per strand.
      '{ROW_END,      DATA_W'(np2b_pkg::CHAR_A), CHECK_TYPED,     np2b_pkg::STATUS_MISMATCH},
      '{ROW_SET_SIZE, DATA_W'(1),                CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(np2b_pkg::CHAR_A), CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(8'h00),            CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(np2b_pkg::CHAR_T), CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_END,      DATA_W'(8'hFF),            CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      // Excess codes after the pair is complete, with noise bytes between.
      '{ROW_CHAR,     DATA_W'(np2b_pkg::CHAR_G), CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(8'hFF),            CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(8'hC1),            CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(np2b_pkg::CHAR_C), CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(np2b_pkg::CHAR_T), CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(np2b_pkg::CHAR_A), CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_END,      DATA_W'(8'h00),            CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      // Sequential mode with a genome size of zero.
      '{ROW_SET_MODE, DATA_W'(0),                CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_SET_SIZE, DATA_W'(0),                CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_END,      DATA_W'(np2b_pkg::CHAR_T), CHECK_TYPED,     np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(np2b_pkg::CHAR_C), CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_END,      DATA_W'(np2b_pkg::CHAR_G), CHECK_TYPED,     np2b_pkg::STATUS_MISMATCH},
      // One code per strand: both strands flush before the end marker.
      '{ROW_SET_SIZE, DATA_W'(1),                CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(np2b_pkg::CHAR_G), CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(np2b_pkg::CHAR_T), CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_END,      DATA_W'(np2b_pkg::CHAR_A), CHECK_TYPED,     np2b_pkg::STATUS_OK},
      // Largest genome size: a short stream ends with a partial word.
      '{ROW_SET_SIZE, SIZE_MAX,                  CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(np2b_pkg::CHAR_T), CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(8'h67),            CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_END,      DATA_W'(np2b_pkg::CHAR_C), CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      // Mode change in the middle of a stream.
      '{ROW_SET_SIZE, DATA_W'(3),                CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(np2b_pkg::CHAR_A), CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(np2b_pkg::CHAR_C), CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_SET_MODE, DATA_W'(1),                CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(np2b_pkg::CHAR_G), CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_CHAR,     DATA_W'(np2b_pkg::CHAR_T), CHECK_PREDICTED, np2b_pkg::STATUS_OK},
      '{ROW_END,      DATA_W'(8'h00),            CHECK_PREDICTED, np2b_pkg::STATUS_OK}
   };

   // Register copies and stream state of the packing model.
   logic                         interleaved_cfg;
   logic [SIZE_W-1:0]            genome_size_cfg;
   logic [WORD_W-1:0]            strand_word [2];
   logic [np2b_pkg::SLOT_W-1:0]  fill_slot;
   logic [COUNT_W-1:0]           codes_taken;
   logic                         fill_strand;
   logic [np2b_pkg::INDEX_W-1:0] word_number;

   np2b_pkg::response_type item_results [$];
   np2b_pkg::response_type expected_results [$];

   int items_sent    = 0;
   int error_count   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_request  = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   function automatic void clear_stream_state();
      strand_word[0] = '0;
      strand_word[1] = '0;
      fill_slot      = '0;
      codes_taken    = '0;
      fill_strand    = 1'b0;
      word_number    = '0;
   endfunction

   function automatic void emit_word(input logic strand, input logic [WORD_W-1:0] word);
      np2b_pkg::response_type result;
      result = '{kind: np2b_pkg::KIND_DATA, strand: strand, word_index: word_number,
                 packed_word: word, status: np2b_pkg::STATUS_OK, last_of_item: 1'b0};
      item_results = {item_results, result};
   endfunction

   // Sequential mode: flush the strand's partial word and start a fresh one.
   function automatic void close_sequential_word();
      if (fill_slot != 0) begin
         emit_word(fill_strand, strand_word[fill_strand]);
         word_number++;
      end
      strand_word[fill_strand] = '0;
      fill_slot = '0;
   endfunction

   // Works out the results that one accepted character or end marker causes.
   function automatic void predict_results(input np2b_pkg::request_type item);
      logic [COUNT_W-1:0]     full_count;
      logic [1:0]             code;
      logic                   is_base;
      np2b_pkg::response_type status_result;
      full_count = {genome_size_cfg, 1'b0};
      item_results.delete();
      is_base = 1'b1;
      code = np2b_pkg::CODE_A;
      if (item.end_of_input) begin
         if (interleaved_cfg) begin
            if (fill_slot != 0 || fill_strand)
               emit_word(1'b0, strand_word[0]);
            if (fill_slot != 0)
               emit_word(1'b1, strand_word[1]);
         end else if (fill_slot != 0) begin
            emit_word(fill_strand, strand_word[fill_strand]);
         end
         status_result = '{kind: np2b_pkg::KIND_STATUS, strand: 1'b0, word_index: '0,
                           packed_word: '0, last_of_item: 1'b0,
                           status: (codes_taken != full_count) ? np2b_pkg::STATUS_MISMATCH
                                                               : np2b_pkg::STATUS_OK};
         item_results = {item_results, status_result};
         clear_stream_state();
      end else begin
         case (item.char_code)
            np2b_pkg::CHAR_A: code = np2b_pkg::CODE_A;
            np2b_pkg::CHAR_C: code = np2b_pkg::CODE_C;
            np2b_pkg::CHAR_G: code = np2b_pkg::CODE_G;
            np2b_pkg::CHAR_T: code = np2b_pkg::CODE_T;
            default: is_base = 1'b0;
         endcase
         if (is_base && codes_taken < full_count) begin
            strand_word[fill_strand] |= WORD_W'(code) << (2 * fill_slot);
            if (interleaved_cfg) begin
               // Strand 1 closes the pair; a full pair of words leaves together.
               if (!fill_strand) begin
                  fill_strand = 1'b1;
               end else begin
                  fill_strand = 1'b0;
                  if (fill_slot == np2b_pkg::LAST_SLOT) begin
                     emit_word(1'b0, strand_word[0]);
                     emit_word(1'b1, strand_word[1]);
                     strand_word[0] = '0;
                     strand_word[1] = '0;
                     fill_slot = '0;
                     word_number++;
                  end else begin
                     fill_slot++;
                  end
               end
               codes_taken++;
            end else begin
               if (fill_slot == np2b_pkg::LAST_SLOT) begin
                  emit_word(fill_strand, strand_word[fill_strand]);
                  strand_word[fill_strand] = '0;
                  fill_slot = '0;
                  word_number++;
               end else begin
                  fill_slot++;
               end
               codes_taken++;
               // Strand 0 ends at genome_size codes, strand 1 at twice that.
               if (!fill_strand && codes_taken == COUNT_W'(genome_size_cfg)) begin
                  close_sequential_word();
                  word_number = '0;
                  fill_strand = 1'b1;
               end else if (codes_taken == full_count) begin
                  close_sequential_word();
               end
            end
         end else if (is_base && codes_taken == full_count) begin
            // Excess codes only push the count past the expected length.
            codes_taken++;
         end
      end
      if (item_results.size() != 0)
         item_results[item_results.size() - 1].last_of_item = 1'b1;
   endfunction

   // Offers one item after a random idle gap and records its results on transfer.
   task automatic send_item(input np2b_pkg::request_type item, input logic typed,
                            input logic typed_status);
      np2b_pkg::response_type typed_result;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      predict_results(item);
      if (typed) begin
         typed_result = '{kind: np2b_pkg::KIND_STATUS, strand: 1'b0, word_index: '0,
                          packed_word: '0, status: typed_status, last_of_item: 1'b1};
         expected_results = {expected_results, typed_result};
      end else begin
         expected_results = {expected_results, item_results};
      end
      items_sent++;
   endtask

   // Stops offering and waits until the block has delivered everything.
   task automatic drain_and_settle();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [np2b_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == np2b_pkg::CSR_INTERLEAVED_MODE)
         interleaved_cfg = value[0];
      else
         genome_size_cfg = value[SIZE_W-1:0];
      @(posedge clock);
   endtask

   // One stream of code_target nucleotides with noise bytes mixed in, closed
   // by an end marker. At code index change_at the block is drained and a
   // register is rewritten in the middle of the stream.
   task automatic send_stream(input int code_target, input int change_at);
      np2b_pkg::request_type item;
      int                    codes_sent;
      codes_sent = 0;
      while (codes_sent < code_target) begin
         if (codes_sent == change_at) begin
            drain_and_settle();
            if ($urandom_range(0, 1))
               write_register(np2b_pkg::CSR_INTERLEAVED_MODE, DATA_W'(!interleaved_cfg));
            else
               write_register(np2b_pkg::CSR_GENOME_SIZE, DATA_W'($urandom_range(1, 40)));
            change_at = -1;
         end
         item.end_of_input = 1'b0;
         if ($urandom_range(0, 9) == 0) begin
            item.char_code = CHAR_W'($urandom_range(0, 255));
         end else begin
            case ($urandom_range(0, 3))
               0: item.char_code = np2b_pkg::CHAR_A;
               1: item.char_code = np2b_pkg::CHAR_C;
               2: item.char_code = np2b_pkg::CHAR_G;
               default: item.char_code = np2b_pkg::CHAR_T;
            endcase
            codes_sent++;
         end
         send_item(item, CHECK_PREDICTED, np2b_pkg::STATUS_OK);
      end
      item.char_code    = CHAR_W'($urandom_range(0, 255));
      item.end_of_input = 1'b1;
      send_item(item, CHECK_PREDICTED, np2b_pkg::STATUS_OK);
   endtask

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_request != hold_seen) begin
         hold_seen    <= hold_request;
         hold_left    <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Each result transfer is compared with the oldest expectation.
   always @(posedge clock) begin
      np2b_pkg::response_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $error("result with no expectation: kind %0d strand %0d index %0d word %h",
                   rsp_if.payload.kind, rsp_if.payload.strand,
                   rsp_if.payload.word_index, rsp_if.payload.packed_word);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.payload.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_if.payload.kind);
               error_count++;
            end
            if (rsp_if.payload.strand !== want.strand) begin
               $error("strand: expected %0d, got %0d", want.strand, rsp_if.payload.strand);
               error_count++;
            end
            if (rsp_if.payload.word_index !== want.word_index) begin
               $error("word_index: expected %0d, got %0d", want.word_index,
                      rsp_if.payload.word_index);
               error_count++;
            end
            if (rsp_if.payload.packed_word !== want.packed_word) begin
               $error("packed_word: expected %h, got %h", want.packed_word,
                      rsp_if.payload.packed_word);
               error_count++;
            end
            if (rsp_if.payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_if.payload.status);
               error_count++;
            end
            if (rsp_if.payload.last_of_item !== want.last_of_item) begin
               $error("last_of_item: expected %0d, got %0d", want.last_of_item,
                      rsp_if.payload.last_of_item);
               error_count++;
            end
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      directed_row_type      row;
      np2b_pkg::request_type item;
      logic [SIZE_W-1:0]     size_pick;
      int                    pick;
      int                    code_target;
      int                    phase_start;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      interleaved_cfg = np2b_pkg::INTERLEAVED_RESET;
      genome_size_cfg = np2b_pkg::GENOME_SIZE_RESET;
      clear_stream_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed rows, one transfer or register write each.
      foreach (directed_table[i]) begin
         row = directed_table[i];
         case (row.kind)
            ROW_SET_MODE: begin
               drain_and_settle();
               write_register(np2b_pkg::CSR_INTERLEAVED_MODE, row.value);
            end
            ROW_SET_SIZE: begin
               drain_and_settle();
               write_register(np2b_pkg::CSR_GENOME_SIZE, row.value);
            end
            default: begin
               item.char_code    = row.value[CHAR_W-1:0];
               item.end_of_input = (row.kind == ROW_END);
               send_item(item, row.typed, row.typed_status);
            end
         endcase
      end

      // Random streams under four idle and stall patterns.
      for (int phase = 0; phase < 4; phase++) begin
         drain_and_settle();
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 52;
               stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct <= 52;
            end
            default: begin
               send_idle_pct = 23;
               stall_pct <= 23;
            end
         endcase
         phase_start = items_sent;
         if (phase == 0) begin
            // Back-pressure: the receiver holds off while short streams keep
            // producing words, so the queue fills and the input stalls.
            write_register(np2b_pkg::CSR_INTERLEAVED_MODE, DATA_W'(0));
            write_register(np2b_pkg::CSR_GENOME_SIZE, DATA_W'(4));
            hold_request <= hold_request + 1;
            repeat (4) send_stream(8, -1);
         end
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 4) < 2 || items_sent == phase_start) begin
               drain_and_settle();
               write_register(np2b_pkg::CSR_INTERLEAVED_MODE, DATA_W'($urandom_range(0, 1)));
               pick = $urandom_range(0, 15);
               if (pick == 0)
                  size_pick = SIZE_MAX;
               else if (pick == 1)
                  size_pick = '0;
               else if (pick == 2)
                  size_pick = SIZE_W'(1);
               else if (pick < 12)
                  size_pick = SIZE_W'($urandom_range(1, 24));
               else
                  size_pick = SIZE_W'($urandom_range(25, 70));
               write_register(np2b_pkg::CSR_GENOME_SIZE, size_pick);
            end
            // Mostly exact lengths; a few short or long streams and mid-stream writes.
            if (genome_size_cfg > 100)
               code_target = $urandom_range(0, 12);
            else if ($urandom_range(0, 9) < 7)
               code_target = 2 * genome_size_cfg;
            else
               code_target = 2 * genome_size_cfg + $urandom_range(0, 6) - 3;
            if ($urandom_range(0, 9) == 0 && code_target > 0)
               send_stream(code_target, $urandom_range(0, code_target - 1));
            else
               send_stream(code_target, -1);
         end
      end

      drain_and_settle();
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
